### hdl/palette_range_rotator_unit_assert.svh
`ifndef PALETTE_RANGE_ROTATOR_UNIT_ASSERT_SVH
`define PALETTE_RANGE_ROTATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PRR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error("palette range rotator check failed");
`define PRR_ASSERT_NEXT(label, clk, rst, ante, cons) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error("palette range rotator check failed");
`else
`define PRR_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PRR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hdl/prr_pkg.sv
package prr_pkg;

   localparam int COLOR_W    = 32;
   localparam int INDEX_W    = 8;
   localparam int SHIFT_W    = 16;
   localparam int START_W    = 8;
   localparam int STOP_W     = 9;
   localparam int BIT_CNT_W  = $clog2(SHIFT_W);
   localparam int ADDR_W_MAX = 12;
   localparam int CMP_W      = 13;
   localparam int RANGE_MAX  = 256;

   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_ROTL  = 2'd2;
   localparam logic [1:0] ACT_ROTR  = 2'd3;

   typedef struct packed {
      logic [1:0]          action;
      logic [INDEX_W-1:0]  entry_index;
      logic [COLOR_W-1:0]  entry_color;
      logic [SHIFT_W-1:0]  shift_amount;
      logic [START_W-1:0]  range_start;
      logic [STOP_W-1:0]   range_stop;
   } req_type;

   typedef struct packed {
      logic [COLOR_W-1:0]  read_color;
      logic                accepted;
   } rsp_type;

   typedef struct packed {
      logic                start;
      logic [SHIFT_W-1:0]  dividend;
      logic [STOP_W-1:0]   divisor;
   } mod_req_type;

   typedef struct packed {
      logic                done;
      logic [STOP_W-1:0]   remainder;
   } mod_rsp_type;

endpackage

### hdl/palette_range_rotator_unit.sv
// Palette range rotator: a color lookup table of TABLE_ENTRIES RGBA words.
// Requests enter on req_valid/req_stall as one req_data word: write an
// entry, read an entry, or rotate the range [range_start, range_stop) left
// or right by shift_amount modulo its length. Each request gives one
// rsp_data word on rsp_valid/rsp_stall: read_color for a read (else zero)
// and accepted, low for an index beyond the table or an invalid range.
// One request is worked on at a time; req_stall is high until it is done.
// A write or a rejected request goes from decode straight to the finish
// step; a read of a valid index first reads the table. A rotate is bound
// by the single table port pair: after a shift-subtract remainder step,
// every entry of the range is read into a scratch memory, then copied
// back, one entry a cycle. The next request can be taken at the earliest
// in the same cycle in which rsp_valid rises.
// After reset the table is loaded with a grayscale ramp (alpha 255), one
// entry a cycle, with req_stall high until it is done.
// The result sits in an output register; while rsp_stall is high the
// block may take and finish one more request, then holds until the
// output register frees.
`include "palette_range_rotator_unit_assert.svh"

module palette_range_rotator_unit #(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  prr_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output prr_pkg::rsp_type  rsp_data
);

   localparam int AW        = $clog2(TABLE_ENTRIES);
   localparam int SCR_DEPTH = (TABLE_ENTRIES < prr_pkg::RANGE_MAX) ?
                              TABLE_ENTRIES : prr_pkg::RANGE_MAX;
   localparam int SW        = $clog2(SCR_DEPTH);
   localparam int LW        = prr_pkg::STOP_W;

   localparam logic [2:0] S_INIT    = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_DECODE  = 3'd2;
   localparam logic [2:0] S_READ    = 3'd3;
   localparam logic [2:0] S_MOD     = 3'd4;
   localparam logic [2:0] S_GATHER  = 3'd5;
   localparam logic [2:0] S_SCATTER = 3'd6;
   localparam logic [2:0] S_FINISH  = 3'd7;

   logic [2:0]                      state_ff, state_in;
   logic [AW-1:0]                   init_cnt_ff, init_cnt_in;
   prr_pkg::req_type                req_ff, req_in;
   logic [LW-1:0]                   len_ff, len_in;
   logic [LW-1:0]                   src_ff, src_in;
   logic [LW-1:0]                   cnt_ff, cnt_in;
   logic                            pipe_vld_ff, pipe_vld_in;
   logic [LW-1:0]                   pipe_idx_ff, pipe_idx_in;
   logic [prr_pkg::COLOR_W-1:0]     res_color_ff, res_color_in;
   logic                            res_ok_ff, res_ok_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   prr_pkg::rsp_type                rsp_ff, rsp_in;

   logic                            idx_ok;
   logic                            range_ok;
   logic [LW-1:0]                   len_calc;
   logic [LW-1:0]                   rot_k;
   logic                            issue;
   logic [LW-1:0]                   gath_addr;
   logic [LW-1:0]                   scat_addr;
   logic [prr_pkg::ADDR_W_MAX-1:0]  idx_wide;
   logic [prr_pkg::ADDR_W_MAX-1:0]  gath_wide;
   logic [prr_pkg::ADDR_W_MAX-1:0]  scat_wide;
   logic [prr_pkg::ADDR_W_MAX-1:0]  init_wide;
   logic [7:0]                      gray;

   logic                            tbl_we;
   logic [AW-1:0]                   tbl_waddr;
   logic [prr_pkg::COLOR_W-1:0]     tbl_wdata;
   logic [AW-1:0]                   tbl_raddr;
   logic [prr_pkg::COLOR_W-1:0]     tbl_rdata;
   logic                            scr_we;
   logic [SW-1:0]                   scr_waddr;
   logic [SW-1:0]                   scr_raddr;
   logic [prr_pkg::COLOR_W-1:0]     scr_rdata;

   prr_pkg::mod_req_type            mod_req;
   prr_pkg::mod_rsp_type            mod_rsp;

   prr_ram #(
      .DEPTH  (TABLE_ENTRIES),
      .ADDR_W (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   prr_ram #(
      .DEPTH  (SCR_DEPTH),
      .ADDR_W (SW)
   ) u_scratch (
      .clock   (clock),
      .wr_en   (scr_we),
      .wr_addr (scr_waddr),
      .wr_data (tbl_rdata),
      .rd_addr (scr_raddr),
      .rd_data (scr_rdata)
   );

   prr_mod_unit u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   assign idx_ok   = prr_pkg::CMP_W'(req_ff.entry_index) < prr_pkg::CMP_W'(TABLE_ENTRIES);
   assign range_ok = (prr_pkg::CMP_W'(req_ff.range_stop) <= prr_pkg::CMP_W'(TABLE_ENTRIES))
                     && ({1'b0, req_ff.range_start} < req_ff.range_stop);
   assign len_calc = req_ff.range_stop - {1'b0, req_ff.range_start};
   assign rot_k    = (req_ff.action == prr_pkg::ACT_ROTR && mod_rsp.remainder != '0) ?
                     len_ff - mod_rsp.remainder : mod_rsp.remainder;
   assign issue    = cnt_ff != len_ff;

   assign gath_addr = {1'b0, req_ff.range_start} + src_ff;
   assign scat_addr = {1'b0, req_ff.range_start} + pipe_idx_ff;
   assign idx_wide  = prr_pkg::ADDR_W_MAX'(req_ff.entry_index);
   assign gath_wide = prr_pkg::ADDR_W_MAX'(gath_addr);
   assign scat_wide = prr_pkg::ADDR_W_MAX'(scat_addr);
   assign init_wide = prr_pkg::ADDR_W_MAX'(init_cnt_ff);
   assign gray      = init_wide[7:0];

   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      state_in     = state_ff;
      init_cnt_in  = init_cnt_ff;
      req_in       = req_ff;
      len_in       = len_ff;
      src_in       = src_ff;
      cnt_in       = cnt_ff;
      pipe_vld_in  = 1'b0;
      pipe_idx_in  = pipe_idx_ff;
      res_color_in = res_color_ff;
      res_ok_in    = res_ok_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      tbl_we    = 1'b0;
      tbl_waddr = idx_wide[AW-1:0];
      tbl_wdata = req_ff.entry_color;
      tbl_raddr = idx_wide[AW-1:0];
      scr_we    = 1'b0;
      scr_waddr = pipe_idx_ff[SW-1:0];
      scr_raddr = cnt_ff[SW-1:0];

      mod_req.start    = 1'b0;
      mod_req.dividend = req_ff.shift_amount;
      mod_req.divisor  = len_calc;

      case (state_ff)
         S_INIT: begin
            tbl_we    = 1'b1;
            tbl_waddr = init_cnt_ff;
            tbl_wdata = {8'hFF, gray, gray, gray};
            init_cnt_in = init_cnt_ff + 1'b1;
            if (init_cnt_ff == AW'(TABLE_ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_color_in = '0;
            res_ok_in    = 1'b0;
            len_in       = len_calc;
            case (req_ff.action)
               prr_pkg::ACT_WRITE: begin
                  tbl_we    = idx_ok;
                  res_ok_in = idx_ok;
                  state_in  = S_FINISH;
               end
               prr_pkg::ACT_READ: begin
                  state_in = idx_ok ? S_READ : S_FINISH;
               end
               default: begin
                  if (range_ok) begin
                     mod_req.start = 1'b1;
                     state_in      = S_MOD;
                  end else begin
                     state_in = S_FINISH;
                  end
               end
            endcase
         end
         S_READ: begin
            res_color_in = tbl_rdata;
            res_ok_in    = 1'b1;
            state_in     = S_FINISH;
         end
         S_MOD: begin
            if (mod_rsp.done) begin
               src_in   = rot_k;
               cnt_in   = '0;
               state_in = S_GATHER;
            end
         end
         S_GATHER: begin
            // copy the rotated range out to scratch, one entry a cycle
            tbl_raddr = gath_wide[AW-1:0];
            scr_we    = pipe_vld_ff;
            if (issue) begin
               src_in      = (src_ff == len_ff - 1'b1) ? '0 : src_ff + 1'b1;
               cnt_in      = cnt_ff + 1'b1;
               pipe_vld_in = 1'b1;
               pipe_idx_in = cnt_ff;
            end else if (!pipe_vld_ff) begin
               cnt_in   = '0;
               state_in = S_SCATTER;
            end
         end
         S_SCATTER: begin
            // copy scratch back into the range in order
            tbl_we    = pipe_vld_ff;
            tbl_waddr = scat_wide[AW-1:0];
            tbl_wdata = scr_rdata;
            if (issue) begin
               cnt_in      = cnt_ff + 1'b1;
               pipe_vld_in = 1'b1;
               pipe_idx_in = cnt_ff;
            end else if (!pipe_vld_ff) begin
               res_ok_in = 1'b1;
               state_in  = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_in.read_color = res_color_ff;
               rsp_in.accepted   = res_ok_ff;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_cnt_ff  <= '0;
         cnt_ff       <= '0;
         pipe_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         cnt_ff       <= cnt_in;
         pipe_vld_ff  <= pipe_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      len_ff       <= len_in;
      src_ff       <= src_in;
      pipe_idx_ff  <= pipe_idx_in;
      res_color_ff <= res_color_in;
      res_ok_ff    <= res_ok_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `PRR_ASSERT_NEXT(a_mod_start_enters_mod, clock, reset, mod_req.start, state_ff == S_MOD)
   `PRR_ASSERT_IMPLY(a_mod_done_in_mod, clock, reset, mod_rsp.done, state_ff == S_MOD)
   `PRR_ASSERT_IMPLY(a_pipe_idx_in_range, clock, reset, pipe_vld_ff, pipe_idx_ff < len_ff)
   `PRR_ASSERT_IMPLY(a_cnt_bounded, clock, reset,
                     (state_ff == S_GATHER || state_ff == S_SCATTER), cnt_ff <= len_ff)
   `PRR_ASSERT_IMPLY(a_color_only_when_ok, clock, reset, rsp_valid_ff && rsp_ff.read_color != '0, rsp_ff.accepted)

endmodule

### hdl/prr_ram.sv
module prr_ram #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [prr_pkg::COLOR_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [prr_pkg::COLOR_W-1:0]  rd_data
);

   logic [prr_pkg::COLOR_W-1:0] mem [DEPTH];
   logic [prr_pkg::COLOR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/prr_mod_unit.sv
module prr_mod_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  prr_pkg::mod_req_type  mod_req,
   output prr_pkg::mod_rsp_type  mod_rsp
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [prr_pkg::BIT_CNT_W-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [prr_pkg::SHIFT_W-1:0]      dvd_ff, dvd_in;
   logic [prr_pkg::STOP_W-1:0]       dvs_ff, dvs_in;
   logic [prr_pkg::STOP_W-1:0]       rem_ff, rem_in;
   logic [prr_pkg::STOP_W:0]         trial;
   logic [prr_pkg::STOP_W:0]         diff;

   assign trial = {rem_ff, dvd_ff[prr_pkg::SHIFT_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      bit_cnt_in = bit_cnt_ff;
      dvd_in     = dvd_ff;
      dvs_in     = dvs_ff;
      rem_in     = rem_ff;
      if (busy_ff) begin
         // one quotient bit a cycle, keep only the remainder
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[prr_pkg::STOP_W-1:0];
         end else begin
            rem_in = trial[prr_pkg::STOP_W-1:0];
         end
         dvd_in     = {dvd_ff[prr_pkg::SHIFT_W-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff - 1'b1;
         if (bit_cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (mod_req.start) begin
         busy_in    = 1'b1;
         bit_cnt_in = prr_pkg::BIT_CNT_W'(prr_pkg::SHIFT_W - 1);
         dvd_in     = mod_req.dividend;
         dvs_in     = mod_req.divisor;
         rem_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         done_ff    <= 1'b0;
         bit_cnt_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         done_ff    <= done_in;
         bit_cnt_ff <= bit_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign mod_rsp.done      = done_ff;
   assign mod_rsp.remainder = rem_ff;

endmodule
